### design/assert_macros.svh
// Assertion macros shared by the open list store modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every aclk edge outside reset.
`define AOLQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Condition in one cycle implies a condition in the next.
`define AOLQ_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

### design/aolq_pkg.sv
// Shared types and constants of the A* open list store.
package aolq_pkg;

    localparam int ACTION_W = 2;
    localparam int NODE_W   = 10;
    localparam int PRED_W   = 11;
    localparam int DIST_W   = 24;
    localparam int EST_W    = DIST_W + 1;
    localparam int STATUS_W = 2;

    localparam int NODE_POOL_DEF = 256;
    localparam int ID_SPACE_DEF  = 1024;

    localparam logic [PRED_W-1:0] PRED_NONE = 11'd1024;
    localparam logic [DIST_W-1:0] DIST_MAX  = 24'hFFFFFF;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_SET_OPEN    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_UPDATE_OPEN = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_BEST    = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_GAIN = 2'd3;

    // per-id mark bits
    localparam int MARK_W      = 2;
    localparam int MARK_OPEN   = 0;
    localparam int MARK_LISTED = 1;

    typedef enum logic [1:0] {
        QOP_NONE,
        QOP_INSERT,
        QOP_MOVE,
        QOP_POP
    } qop_t;

    // control handed from the queue to each cell
    typedef struct packed {
        qop_t op;
        logic shift_en;
        logic left_gt;
    } qctl_t;

    typedef struct packed {
        logic [PRED_W-1:0] pred;
        logic [DIST_W-1:0] path_dist;
        logic [DIST_W-1:0] heur;
    } info_t;

endpackage

### design/astar_open_list_store.sv
// Top level of the A* open and closed node store with sorted open queue.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_valid / s_ready  | action, node_id, pred_id, heur, length
//  m_      | out | m_valid / m_ready  | status, best_id, best_pred, best_dist
//
// Sequencing: one request at a time. set_open: RD_NODE, RD_PRED, DONE; a pop
//   that finds a node: RD_NODE, POP_RD, DONE; an empty pop and the unused code:
//   RD_NODE, DONE; update_open: RD_NODE, RD_PRED, EVAL, CMP, APPLY, DONE. The
//   per-id tables are single-read RAMs, so node and predecessor entries are
//   fetched in turn; relax add, compare and queue move each have a state.
// Reset: synchronous, active low. Afterwards the mark table is swept clear,
//   one id a cycle, over all ID_SPACE ids; s_ready stays low meanwhile.
// Stalls: a result waits in the output register while the next request is
//   accepted and worked on; the following result then waits with s_ready low.
`include "assert_macros.svh"

module astar_open_list_store #(
    parameter int NODE_POOL = aolq_pkg::NODE_POOL_DEF,
    parameter int ID_SPACE  = aolq_pkg::ID_SPACE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [aolq_pkg::ACTION_W-1:0] s_action,
    input  logic [aolq_pkg::NODE_W-1:0]   s_node_id,
    input  logic [aolq_pkg::PRED_W-1:0]   s_pred_id,
    input  logic [aolq_pkg::DIST_W-1:0]   s_heur,
    input  logic [aolq_pkg::DIST_W-1:0]   s_length,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [aolq_pkg::STATUS_W-1:0] m_status,
    output logic [aolq_pkg::NODE_W-1:0]   m_best_id,
    output logic [aolq_pkg::PRED_W-1:0]   m_best_pred,
    output logic [aolq_pkg::DIST_W-1:0]   m_best_dist
);
    import aolq_pkg::*;

    localparam int IDX_W  = $clog2(ID_SPACE);
    localparam int USED_W = $clog2(NODE_POOL + 1);

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_NODE,
        S_RD_PRED,
        S_EVAL,
        S_CMP,
        S_APPLY,
        S_POP_RD,
        S_DONE
    } state_t;

    state_t state_reg;

    // captured request
    logic [ACTION_W-1:0] action_reg;
    logic [NODE_W-1:0]   node_reg;
    logic [PRED_W-1:0]   pred_reg;
    logic [DIST_W-1:0]   heur_reg;
    logic [DIST_W-1:0]   len_reg;

    // working registers
    idx_t              clr_cnt_reg;
    logic [USED_W-1:0] nodes_used_reg;
    logic [EST_W-1:0]  est_reg;
    logic              node_open_reg;
    logic [DIST_W-1:0] node_dist_reg;
    logic [DIST_W-1:0] node_heur_reg;
    logic [DIST_W-1:0] nd_reg;
    logic              relax_ok_reg;
    logic              improve_reg;

    // pending result
    logic [STATUS_W-1:0] status_reg;
    logic [NODE_W-1:0]   bid_reg;
    logic [PRED_W-1:0]   bpred_reg;
    logic [DIST_W-1:0]   bdist_reg;

    // output register
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [NODE_W-1:0]   m_best_id_reg;
    logic [PRED_W-1:0]   m_best_pred_reg;
    logic [DIST_W-1:0]   m_best_dist_reg;
    logic                out_load;

    // table ports
    logic              mark_we;
    idx_t              mark_waddr, mark_raddr;
    logic [MARK_W-1:0] mark_wdata, mark_rdata;
    logic              info_we;
    idx_t              info_waddr, info_raddr;
    info_t             info_wdata, info_rdata;

    // queue port
    qop_t             q_op;
    idx_t             q_id;
    logic [EST_W-1:0] q_est;
    logic             q_front_valid;
    idx_t             q_front_id;
    logic             q_any_match;

    idx_t             node_idx, pred_idx;
    logic             node_in_range, set_ok, pred_ok;
    logic [EST_W-1:0] relax_sum;

    assign node_idx      = idx_t'(node_reg);
    assign pred_idx      = idx_t'(pred_reg);
    assign node_in_range = 32'(node_reg) < 32'(ID_SPACE);
    // a closed node still counts as listed
    assign set_ok        = node_in_range && (32'(nodes_used_reg) < 32'(NODE_POOL))
                           && !mark_rdata[MARK_LISTED];
    // valid in S_EVAL, where the mark read holds the predecessor
    assign pred_ok       = (pred_reg != PRED_NONE) && (32'(pred_reg) < 32'(ID_SPACE))
                           && mark_rdata[MARK_LISTED];
    assign relax_sum     = {1'b0, info_rdata.path_dist} + {1'b0, len_reg};

    // result moves into the output register once the slot is free
    assign out_load      = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    aolq_ram #(
        .WIDTH(MARK_W),
        .DEPTH(ID_SPACE)
    ) u_mark_ram (
        .aclk (aclk),
        .we   (mark_we),
        .waddr(mark_waddr),
        .wdata(mark_wdata),
        .raddr(mark_raddr),
        .rdata(mark_rdata)
    );

    aolq_ram #(
        .WIDTH($bits(info_t)),
        .DEPTH(ID_SPACE)
    ) u_info_ram (
        .aclk (aclk),
        .we   (info_we),
        .waddr(info_waddr),
        .wdata(info_wdata),
        .raddr(info_raddr),
        .rdata(info_rdata)
    );

    aolq_queue #(
        .NODE_POOL(NODE_POOL),
        .ID_W     (IDX_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (q_op),
        .new_id     (q_id),
        .new_est    (q_est),
        .front_valid(q_front_valid),
        .front_id   (q_front_id),
        .any_match  (q_any_match)
    );

    // table and queue control
    always_comb begin
        mark_we    = 1'b0;
        mark_waddr = node_idx;
        mark_wdata = '0;
        mark_raddr = node_idx;
        info_we    = 1'b0;
        info_waddr = node_idx;
        info_wdata = '{pred: pred_reg, path_dist: len_reg, heur: heur_reg};
        info_raddr = node_idx;
        q_op       = QOP_NONE;
        q_id       = node_idx;
        q_est      = est_reg;
        case (state_reg)
            S_CLEAR: begin
                mark_we    = 1'b1;
                mark_waddr = clr_cnt_reg;
            end
            S_RD_NODE: begin
                // pop: remove front, close it, fetch its pred and dist
                if (action_reg == ACT_POP_BEST && q_front_valid) begin
                    q_op                    = QOP_POP;
                    mark_we                 = 1'b1;
                    mark_waddr              = q_front_id;
                    mark_wdata[MARK_LISTED] = 1'b1;
                    info_raddr              = q_front_id;
                end
            end
            S_RD_PRED: begin
                mark_raddr = pred_idx;
                info_raddr = pred_idx;
                if (action_reg == ACT_SET_OPEN && set_ok) begin
                    mark_we                 = 1'b1;
                    mark_wdata[MARK_LISTED] = 1'b1;
                    mark_wdata[MARK_OPEN]   = 1'b1;
                    info_we                 = 1'b1;
                    q_op                    = QOP_INSERT;
                end
            end
            S_APPLY: begin
                if (improve_reg) begin
                    info_we    = 1'b1;
                    info_wdata = '{pred: pred_reg, path_dist: nd_reg, heur: node_heur_reg};
                    q_op       = QOP_MOVE;
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer, pending result and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            nodes_used_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == idx_t'(ID_SPACE - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        action_reg <= s_action;
                        node_reg   <= s_node_id;
                        pred_reg   <= s_pred_id;
                        heur_reg   <= s_heur;
                        len_reg    <= s_length;
                        bid_reg    <= '0;
                        bpred_reg  <= '0;
                        bdist_reg  <= '0;
                        state_reg  <= S_RD_NODE;
                    end
                end
                S_RD_NODE: begin
                    est_reg <= {1'b0, len_reg} + {1'b0, heur_reg};
                    case (action_reg)
                        ACT_SET_OPEN, ACT_UPDATE_OPEN: begin
                            state_reg <= S_RD_PRED;
                        end
                        ACT_POP_BEST: begin
                            if (q_front_valid) begin
                                status_reg <= ST_DONE;
                                bid_reg    <= NODE_W'(q_front_id);
                                state_reg  <= S_POP_RD;
                            end else begin
                                status_reg <= ST_EMPTY;
                                state_reg  <= S_DONE;
                            end
                        end
                        default: begin
                            status_reg <= ST_REFUSED;
                            state_reg  <= S_DONE;
                        end
                    endcase
                end
                S_RD_PRED: begin
                    if (action_reg == ACT_SET_OPEN) begin
                        status_reg <= set_ok ? ST_DONE : ST_REFUSED;
                        if (set_ok) begin
                            nodes_used_reg <= nodes_used_reg + 1'b1;
                        end
                        state_reg <= S_DONE;
                    end else begin
                        node_open_reg <= node_in_range && mark_rdata[MARK_OPEN];
                        node_dist_reg <= info_rdata.path_dist;
                        node_heur_reg <= info_rdata.heur;
                        state_reg     <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    // relaxed distance saturates
                    nd_reg       <= relax_sum[DIST_W] ? DIST_MAX : relax_sum[DIST_W-1:0];
                    relax_ok_reg <= node_open_reg && pred_ok;
                    state_reg    <= S_CMP;
                end
                S_CMP: begin
                    improve_reg <= relax_ok_reg && (nd_reg < node_dist_reg);
                    est_reg     <= {1'b0, nd_reg} + {1'b0, node_heur_reg};
                    state_reg   <= S_APPLY;
                end
                S_APPLY: begin
                    status_reg <= improve_reg ? ST_DONE : ST_NO_GAIN;
                    state_reg  <= S_DONE;
                end
                S_POP_RD: begin
                    bpred_reg <= info_rdata.pred;
                    bdist_reg <= info_rdata.path_dist;
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        m_status_reg    <= status_reg;
                        m_best_id_reg   <= bid_reg;
                        m_best_pred_reg <= bpred_reg;
                        m_best_dist_reg <= bdist_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_best_id   = m_best_id_reg;
    assign m_best_pred = m_best_pred_reg;
    assign m_best_dist = m_best_dist_reg;

    // open marks and queue contents must agree
    `AOLQ_ASSERT(a_pop_nonempty, (q_op == QOP_POP) |-> q_front_valid, "pop issued on empty queue")
    `AOLQ_ASSERT(a_move_found, (q_op == QOP_MOVE) |-> q_any_match, "open node missing from queue")
    `AOLQ_ASSERT_NEXT(a_insert_front, q_op == QOP_INSERT, q_front_valid, "insert left queue empty")

endmodule

### design/aolq_ram.sv
// Generic single write, single read RAM with registered read data.
module aolq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/aolq_cell.sv
// One slot of the sorted open queue: holds an id and its estimate.
module aolq_cell #(
    parameter int ID_W = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  aolq_pkg::qctl_t           ctl,
    input  logic [ID_W-1:0]           new_id,
    input  logic [aolq_pkg::EST_W-1:0] new_est,
    input  logic                      left_valid,
    input  logic [ID_W-1:0]           left_id,
    input  logic [aolq_pkg::EST_W-1:0] left_est,
    input  logic                      right_valid,
    input  logic [ID_W-1:0]           right_id,
    input  logic [aolq_pkg::EST_W-1:0] right_est,
    output logic                      valid,
    output logic [ID_W-1:0]           id,
    output logic [aolq_pkg::EST_W-1:0] est,
    output logic                      gt,
    output logic                      match
);
    import aolq_pkg::*;

    logic             valid_reg, valid_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [EST_W-1:0] est_reg, est_next;

    // new entry belongs in front of this slot
    assign gt    = !valid_reg || (est_reg > new_est);
    assign match = valid_reg && (id_reg == new_id);

    always_comb begin
        valid_next = valid_reg;
        id_next    = id_reg;
        est_next   = est_reg;
        case (ctl.op)
            QOP_POP: begin
                valid_next = right_valid;
                id_next    = right_id;
                est_next   = right_est;
            end
            QOP_INSERT, QOP_MOVE: begin
                if (ctl.shift_en && gt) begin
                    if (ctl.left_gt) begin
                        valid_next = left_valid;
                        id_next    = left_id;
                        est_next   = left_est;
                    end else begin
                        valid_next = 1'b1;
                        id_next    = new_id;
                        est_next   = new_est;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg  <= id_next;
        est_reg <= est_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign est   = est_reg;

endmodule

### design/aolq_queue.sv
// Sorted open queue built as a row of shifting cells.
`include "assert_macros.svh"

module aolq_queue #(
    parameter int NODE_POOL = aolq_pkg::NODE_POOL_DEF,
    parameter int ID_W      = 10
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  aolq_pkg::qop_t             op,
    input  logic [ID_W-1:0]            new_id,
    input  logic [aolq_pkg::EST_W-1:0] new_est,
    output logic                       front_valid,
    output logic [ID_W-1:0]            front_id,
    output logic                       any_match
);
    import aolq_pkg::*;

    localparam int LVLS = $clog2(NODE_POOL);

    logic             valid_w [NODE_POOL];
    logic [ID_W-1:0]  id_w    [NODE_POOL];
    logic [EST_W-1:0] est_w   [NODE_POOL];
    logic             gt_w    [NODE_POOL];
    logic             match_w [NODE_POOL];

    // suffix OR of the match flags: slot is at or before the moved entry
    logic [NODE_POOL-1:0] suf_lvl [LVLS+1];

    always_comb begin
        for (int i = 0; i < NODE_POOL; i++) begin
            suf_lvl[0][i] = match_w[i];
        end
        for (int k = 0; k < LVLS; k++) begin
            for (int i = 0; i < NODE_POOL; i++) begin
                if (i + (1 << k) < NODE_POOL) begin
                    suf_lvl[k+1][i] = suf_lvl[k][i] | suf_lvl[k][i + (1 << k)];
                end else begin
                    suf_lvl[k+1][i] = suf_lvl[k][i];
                end
            end
        end
    end

    for (genvar i = 0; i < NODE_POOL; i++) begin : g_cell
        qctl_t            ctl;
        logic             l_valid, r_valid;
        logic [ID_W-1:0]  l_id, r_id;
        logic [EST_W-1:0] l_est, r_est;

        if (i == 0) begin : g_head
            assign l_valid = 1'b0;
            assign l_id    = '0;
            assign l_est   = '0;
            assign ctl.left_gt = 1'b0;
        end else begin : g_mid
            assign l_valid = valid_w[i-1];
            assign l_id    = id_w[i-1];
            assign l_est   = est_w[i-1];
            assign ctl.left_gt = gt_w[i-1];
        end

        if (i == NODE_POOL - 1) begin : g_tail
            assign r_valid = 1'b0;
            assign r_id    = '0;
            assign r_est   = '0;
        end else begin : g_body
            assign r_valid = valid_w[i+1];
            assign r_id    = id_w[i+1];
            assign r_est   = est_w[i+1];
        end

        assign ctl.op       = op;
        assign ctl.shift_en = (op == QOP_INSERT) || suf_lvl[LVLS][i];

        aolq_cell #(
            .ID_W(ID_W)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .new_id     (new_id),
            .new_est    (new_est),
            .left_valid (l_valid),
            .left_id    (l_id),
            .left_est   (l_est),
            .right_valid(r_valid),
            .right_id   (r_id),
            .right_est  (r_est),
            .valid      (valid_w[i]),
            .id         (id_w[i]),
            .est        (est_w[i]),
            .gt         (gt_w[i]),
            .match      (match_w[i])
        );
    end

    assign front_valid = valid_w[0];
    assign front_id    = id_w[0];
    assign any_match   = suf_lvl[LVLS][0];

    // occupied slots form a prefix and are ordered by estimate
    for (genvar i = 0; i < NODE_POOL - 1; i++) begin : g_chk
        `AOLQ_ASSERT(a_sorted, valid_w[i+1] |-> (valid_w[i] && (est_w[i] <= est_w[i+1])), "open queue out of order")
    end

endmodule

### sim/tb_astar_open_list_store.sv
// Self-checking testbench of the A* open and closed node store.
`timescale 1ns / 1ps

module tb_astar_open_list_store;
    import aolq_pkg::*;

    localparam int POOL        = NODE_POOL_DEF;
    localparam int IDS         = ID_SPACE_DEF;
    localparam int RAND_REQS   = 1200;
    localparam int PHASE_LEN   = 150;     // requests per idling phase
    localparam int PRESS_AT    = 500;     // accepted requests before the long hold-off
    localparam int PRESS_LEN   = 400;     // cycles the receiver holds off
    localparam int DRAIN_WAIT  = 16;      // idle wait after the last answer
    localparam int CYCLE_LIMIT = 300000;

    // the fourth action code has no name in the package
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [NODE_W-1:0]   node;
        logic [PRED_W-1:0]   pred;
        logic [DIST_W-1:0]   heur;
        logic [DIST_W-1:0]   length;
        int                  phase;
    } req_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [NODE_W-1:0]   best_id;
        logic [PRED_W-1:0]   best_pred;
        logic [DIST_W-1:0]   best_dist;
    } answer_t;

    // one slot of the predicted open list, front is the best node
    typedef struct {
        logic [NODE_W-1:0] id;
        logic [EST_W-1:0]  est;
    } slot_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    logic [ACTION_W-1:0] s_action  = '0;
    logic [NODE_W-1:0]   s_node_id = '0;
    logic [PRED_W-1:0]   s_pred_id = '0;
    logic [DIST_W-1:0]   s_heur    = '0;
    logic [DIST_W-1:0]   s_length  = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [NODE_W-1:0]   m_best_id;
    logic [PRED_W-1:0]   m_best_pred;
    logic [DIST_W-1:0]   m_best_dist;

    // requests still to be offered, and answers the block still owes
    req_t    pending_reqs[$];
    answer_t owed_answers[$];

    // predicted per-id tables; a closed node is simply listed and not open
    logic [PRED_W-1:0] node_pred_tbl[IDS];
    logic [DIST_W-1:0] node_dist_tbl[IDS];
    logic [DIST_W-1:0] node_heur_tbl[IDS];
    bit                is_listed[IDS];
    bit                is_open[IDS];
    slot_t             open_order[$];
    int                pool_used = 0;

    int   errors        = 0;
    int   reqs_accepted = 0;
    int   cur_phase     = 0;
    int   gen_phase     = 0;
    int   hold_left     = 0;
    bit   hold_done     = 1'b0;
    int   cycles        = 0;
    req_t cur_req;

    // tallies for the closing summary
    int n_opened = 0, n_relaxed = 0, n_popped = 0;
    int n_refused = 0, n_empty = 0, n_no_gain = 0;

    astar_open_list_store u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_node_id   (s_node_id),
        .s_pred_id   (s_pred_id),
        .s_heur      (s_heur),
        .s_length    (s_length),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_best_id   (m_best_id),
        .m_best_pred (m_best_pred),
        .m_best_dist (m_best_dist)
    );

    always #10 aclk = ~aclk;

    // Idle odds per phase: 0 none, 1 sender 64%, 2 receiver 64%, 3 both 37%.
    function automatic int gap_percent(input int ph, input bit receiver);
        case (ph)
            1: return receiver ? 0 : 64;
            2: return receiver ? 64 : 0;
            3: return 37;
            default: return 0;
        endcase
    endfunction

    // Sorted insert: a node goes behind every entry with an estimate <= its own,
    // so equal estimates keep arrival order.
    function automatic void queue_by_estimate(input logic [NODE_W-1:0] id,
                                              input logic [EST_W-1:0] est);
        slot_t s;
        int    pos;
        s.id  = id;
        s.est = est;
        pos   = 0;
        if (open_order.size() >= POOL) return;
        while (pos < open_order.size() && open_order[pos].est <= est) pos++;
        open_order.insert(pos, s);
    endfunction

    // Works out the answer of one accepted request and advances the
    // predicted store.
    function automatic answer_t open_list_predict(input req_t rq);
        answer_t        ans;
        logic [EST_W-1:0] relaxed;
        logic [DIST_W-1:0] nd;
        slot_t          front;
        ans.status    = ST_REFUSED;
        ans.best_id   = '0;
        ans.best_pred = '0;
        ans.best_dist = '0;
        case (rq.action)
            ACT_SET_OPEN: begin
                if (pool_used < POOL && !is_listed[rq.node]) begin
                    node_pred_tbl[rq.node] = rq.pred;
                    node_dist_tbl[rq.node] = rq.length;
                    node_heur_tbl[rq.node] = rq.heur;
                    is_listed[rq.node] = 1'b1;
                    is_open[rq.node]   = 1'b1;
                    pool_used++;
                    // estimate is a 25-bit sum, the carry is kept
                    queue_by_estimate(rq.node, {1'b0, rq.length} + {1'b0, rq.heur});
                    ans.status = ST_DONE;
                    n_opened++;
                end else begin
                    n_refused++;
                end
            end
            ACT_UPDATE_OPEN: begin
                ans.status = ST_NO_GAIN;
                if (is_open[rq.node] && rq.pred != PRED_NONE && rq.pred < PRED_W'(IDS)
                        && is_listed[rq.pred[NODE_W-1:0]]) begin
                    relaxed = {1'b0, node_dist_tbl[rq.pred[NODE_W-1:0]]} + {1'b0, rq.length};
                    nd = relaxed[DIST_W] ? DIST_MAX : relaxed[DIST_W-1:0];
                    if (nd < node_dist_tbl[rq.node]) begin
                        for (int i = 0; i < open_order.size(); i++) begin
                            if (open_order[i].id == rq.node) begin
                                open_order.delete(i);
                                break;
                            end
                        end
                        node_pred_tbl[rq.node] = rq.pred;
                        node_dist_tbl[rq.node] = nd;
                        queue_by_estimate(rq.node, {1'b0, nd} + {1'b0, node_heur_tbl[rq.node]});
                        ans.status = ST_DONE;
                        n_relaxed++;
                    end
                end
                if (ans.status == ST_NO_GAIN) n_no_gain++;
            end
            ACT_POP_BEST: begin
                if (open_order.size() == 0) begin
                    ans.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    front = open_order[0];
                    open_order.delete(0);
                    is_open[front.id] = 1'b0;
                    ans.status    = ST_DONE;
                    ans.best_id   = front.id;
                    ans.best_pred = node_pred_tbl[front.id];
                    ans.best_dist = node_dist_tbl[front.id];
                    n_popped++;
                end
            end
            default: n_refused++;   // unused action code
        endcase
        return ans;
    endfunction

    task automatic push_req(input logic [ACTION_W-1:0] action, input logic [NODE_W-1:0] node,
                            input logic [PRED_W-1:0] pred, input logic [DIST_W-1:0] heur,
                            input logic [DIST_W-1:0] length);
        req_t rq;
        rq.action = action;
        rq.node   = node;
        rq.pred   = pred;
        rq.heur   = heur;
        rq.length = length;
        rq.phase  = gen_phase;
        pending_reqs.insert(pending_reqs.size(), rq);
    endtask

    task automatic check_field(input string name, input logic [DIST_W-1:0] want,
                               input logic [DIST_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    // Driver: offers the next pending request, predicts each one on accept.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                owed_answers.insert(owed_answers.size(), open_list_predict(cur_req));
                reqs_accepted <= reqs_accepted + 1;
            end
            // a new request may go out only once the held one is taken
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() != 0
                        && $urandom_range(99) >= gap_percent(pending_reqs[0].phase, 1'b0)) begin
                    cur_req = pending_reqs[0];
                    pending_reqs.delete(0);
                    s_action  <= cur_req.action;
                    s_node_id <= cur_req.node;
                    s_pred_id <= cur_req.pred;
                    s_heur    <= cur_req.heur;
                    s_length  <= cur_req.length;
                    cur_phase <= cur_req.phase;
                    s_valid   <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, once, partway through the random part.
    always @(posedge aclk) begin
        if (!hold_done && reqs_accepted == PRESS_AT) begin
            hold_left <= PRESS_LEN;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: checks each accepted answer against the oldest one owed.
    always @(posedge aclk) begin : monitor
        answer_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (owed_answers.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected answer, actual status %0d id %0d", $time,
                             m_status, m_best_id);
                end else begin
                    want = owed_answers[0];
                    owed_answers.delete(0);
                    check_field("status", DIST_W'(want.status), DIST_W'(m_status));
                    check_field("best_id", DIST_W'(want.best_id), DIST_W'(m_best_id));
                    check_field("best_pred", DIST_W'(want.best_pred), DIST_W'(m_best_pred));
                    check_field("best_dist", want.best_dist, m_best_dist);
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= gap_percent(cur_phase, 1'b1));
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d answers still owed", cycles,
                     owed_answers.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        logic [NODE_W-1:0] used_ids[$];
        bit                gen_used[IDS];
        logic [NODE_W-1:0] id;
        logic [PRED_W-1:0] pred;
        logic [DIST_W-1:0] heur, len;
        int                r, tries;

        // Directed part: empty pop, refusals, tie order, relax, saturation,
        // updates of closed nodes and odd predecessors.
        push_req(ACT_POP_BEST, 10'd0, 11'd0, 24'd0, 24'd0);                 // empty list
        push_req(ACT_UPDATE_OPEN, 10'd3, 11'd0, 24'd0, 24'd1);              // never listed
        push_req(ACT_SET_OPEN, 10'd0, PRED_NONE, 24'h000200, 24'h000100);   // start node
        push_req(ACT_SET_OPEN, 10'd1023, 11'd0, DIST_MAX, DIST_MAX);        // 25-bit estimate
        push_req(ACT_SET_OPEN, 10'd0, 11'd0, 24'd0, 24'd0);                 // already listed
        push_req(ACT_SET_OPEN, 10'd5, 11'd0, 24'd0, 24'h000300);            // ties node 0
        push_req(ACT_UPDATE_OPEN, 10'd1023, 11'd0, DIST_MAX, 24'h000010);   // relaxes
        push_req(ACT_UPDATE_OPEN, 10'd1023, PRED_NONE, 24'd0, 24'd0);       // no predecessor
        push_req(ACT_UPDATE_OPEN, 10'd1023, 11'd2047, 24'd0, 24'd0);        // pred out of range
        push_req(ACT_UPDATE_OPEN, 10'd1023, 11'd7, 24'd0, 24'd0);           // pred not listed
        push_req(ACT_UPDATE_OPEN, 10'd1023, 11'd0, 24'd0, 24'h000020);      // no improvement
        push_req(ACT_UNUSED, 10'h3FF, 11'h7FF, DIST_MAX, DIST_MAX);         // unused code
        push_req(ACT_SET_OPEN, 10'd10, 11'd1023, 24'd0, 24'hFFFFF0);
        push_req(ACT_UPDATE_OPEN, 10'd5, 11'd10, 24'd0, DIST_MAX);          // saturates
        push_req(ACT_POP_BEST, 10'd0, 11'd0, 24'd0, 24'd0);                 // closes node 0
        push_req(ACT_SET_OPEN, 10'd0, 11'd0, 24'd0, 24'd0);                 // closed is listed
        push_req(ACT_UPDATE_OPEN, 10'd0, 11'd5, 24'd0, 24'd0);              // closed node
        push_req(ACT_UPDATE_OPEN, 10'd5, 11'd0, 24'd0, 24'd0);              // via closed pred
        repeat (5) push_req(ACT_POP_BEST, 10'd0, 11'd0, 24'd0, 24'd0);      // drain past empty
        foreach (gen_used[i]) gen_used[i] = 1'b0;
        used_ids = '{10'd0, 10'd1023, 10'd5, 10'd10};
        foreach (used_ids[i]) gen_used[used_ids[i]] = 1'b1;

        // Random part: mostly well-formed open / relax / pop traffic over the
        // ids handed out so far, some noise. Phases rotate every PHASE_LEN.
        for (int n = 0; n < RAND_REQS; n++) begin
            gen_phase = (n / PHASE_LEN) % 4;
            r = $urandom_range(99);
            if (r < 8) begin
                push_req(ACTION_W'($urandom_range(3)), NODE_W'($urandom), PRED_W'($urandom),
                         DIST_W'($urandom), DIST_W'($urandom));
            end else if (r < 42) begin
                id = NODE_W'($urandom);
                tries = 0;
                if ($urandom_range(9) != 0) begin
                    while (gen_used[id] && tries < 64) begin
                        id = NODE_W'($urandom);
                        tries++;
                    end
                end else begin
                    id = used_ids[$urandom_range(used_ids.size() - 1)];
                end
                if (!gen_used[id]) begin
                    gen_used[id] = 1'b1;
                    used_ids.insert(used_ids.size(), id);
                end
                pred = ($urandom_range(9) != 0) ? PRED_W'(used_ids[$urandom_range(used_ids.size() - 1)])
                                               : PRED_NONE;
                heur = ($urandom_range(3) == 0) ? DIST_W'($urandom) : DIST_W'($urandom_range(24'h00FFFF));
                len  = ($urandom_range(3) == 0) ? DIST_W'($urandom) : DIST_W'($urandom_range(24'h3FFFFF));
                push_req(ACT_SET_OPEN, id, pred, heur, len);
            end else if (r < 72) begin
                id   = used_ids[$urandom_range(used_ids.size() - 1)];
                pred = ($urandom_range(9) != 0) ? PRED_W'(used_ids[$urandom_range(used_ids.size() - 1)])
                                               : PRED_W'($urandom_range(IDS, 2047));
                len  = ($urandom_range(4) == 0) ? DIST_W'($urandom) : DIST_W'($urandom_range(24'h0FFFFF));
                push_req(ACT_UPDATE_OPEN, id, pred, DIST_W'($urandom), len);
            end else begin
                push_req(ACT_POP_BEST, NODE_W'($urandom), PRED_W'($urandom), DIST_W'($urandom),
                         DIST_W'($urandom));
            end
        end

        // single reset, then let the block sweep its marks and run
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_valid) @(posedge aclk);
        while (owed_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("%0d requests: %0d opened, %0d relaxed, %0d popped", reqs_accepted,
                 n_opened, n_relaxed, n_popped);
        $display("refused %0d, empty pops %0d, no-gain updates %0d, mismatches %0d",
                 n_refused, n_empty, n_no_gain, errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
